// ===== hw/rtl/ryc_pkg.sv =====
// Shared types and constants of the BT.601 RGB / YPbPr converter.
// Used by every module of the block; depends on nothing.
package ryc_pkg;

  // Configuration register indexes.
  localparam logic CFG_DIRECTION = 1'b0;
  localparam logic CFG_MAX_VALUE = 1'b1;

  // Direction codes.
  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_INV = 1'b1;

  localparam int NW = 51; // dividend width
  localparam int DW = 34; // divisor width
  localparam int QW = 18; // quotient bits, one per divider stage
  localparam int PW = 38; // product width
  localparam int SW = 40; // lane sum width
  localparam int AW = 34; // magnitude width

  // Operand codes of the inverse lanes.
  localparam logic [1:0] OP_Y  = 2'd0;
  localparam logic [1:0] OP_PB = 2'd1;
  localparam logic [1:0] OP_PR = 2'd2;

  // Coefficients scaled by 10^6 and divided by 8 (all of them are multiples of 8).
  localparam logic signed [19:0] FWD_C [3][3] = '{
    '{20'sd37375, 20'sd73375, 20'sd14250},
    '{-20'sd21092, -20'sd41408, 20'sd62500},
    '{20'sd62500, -20'sd52336, -20'sd10164}
  };
  localparam logic signed [19:0] INV_C [3][3] = '{
    '{20'sd125000, 20'sd175250, 20'sd0},
    '{20'sd125000, -20'sd43017, -20'sd89267},
    '{20'sd125000, 20'sd221500, 20'sd0}
  };
  localparam logic [1:0] INV_SEL [3][3] = '{
    '{OP_Y, OP_PR, OP_PR},
    '{OP_Y, OP_PB, OP_PR},
    '{OP_Y, OP_PB, OP_PB}
  };

  localparam logic [DW-1:0] FWD_DIV_K  = 34'd250000;
  localparam logic [NW-1:0] FWD_HALF_K = 51'd125000;
  localparam logic [DW-1:0] INV_DSR    = 34'd16384000000;
  localparam logic [NW-1:0] INV_HALF   = 51'd8192000000;
  localparam logic signed [SW-1:0] INV_TOP = 40'sd8192000000;

  typedef struct packed {
    logic [NW:0]   rem;
    logic [QW-1:0] quo;
    logic          neg;
    logic          ovf;
  } div_lane_t;

  typedef struct packed {
    logic            vld;
    logic            dir;
    logic [DW-1:0]   dsr;
    div_lane_t [2:0] lane;
  } div_word_t;

endpackage

// ===== hw/rtl/ryc_prep.sv =====
// Front pipeline: coefficient products, lane sums, clamps and dividend forming.
// Depends on ryc_pkg; feeds ryc_div.
module ryc_prep (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    vld,
  input  logic                    dir,
  input  logic [15:0]             den,
  input  logic [15:0]             red,
  input  logic [15:0]             green,
  input  logic [15:0]             blue,
  input  logic [16:0]             luma,
  input  logic signed [16:0]      pb,
  input  logic signed [16:0]      pr,
  output ryc_pkg::div_word_t      dw
);

  logic signed [17:0] opnd [3][3];
  logic signed [19:0] coef [3][3];
  logic signed [17:0] fop [3];

  logic signed [ryc_pkg::PW-1:0] term_r [3][3];
  logic signed [ryc_pkg::PW-1:0] term_nxt [3][3];
  logic signed [ryc_pkg::SW-1:0] sum_r [3];
  logic signed [ryc_pkg::SW-1:0] sum_nxt [3];
  logic signed [ryc_pkg::SW-1:0] absv [3];
  logic [ryc_pkg::AW-1:0] mag_r [3];
  logic [ryc_pkg::AW-1:0] mag_nxt [3];
  logic [2:0]  neg_c_r, neg_c_nxt, neg_d_r;
  logic [ryc_pkg::NW-1:0] num_r [3];
  logic [ryc_pkg::NW-1:0] num_nxt [3];
  logic [ryc_pkg::NW-1:0] prod [3];
  logic [ryc_pkg::DW-1:0] den_x;
  logic [ryc_pkg::DW-1:0] dsr_c_r, dsr_c_nxt, dsr_d_r;
  logic [ryc_pkg::NW-1:0] half_f;
  logic [3:0]  vld_r;
  logic [3:0]  dir_r;
  logic [15:0] den_a_r, den_b_r, den_c_r;
  ryc_pkg::div_word_t dw_r, dw_nxt;

  // Stage A: nine multipliers shared by both directions.
  always_comb begin
    fop[0] = {2'b00, red};
    fop[1] = {2'b00, green};
    fop[2] = {2'b00, blue};
    for (int l = 0; l < 3; l++) begin
      for (int k = 0; k < 3; k++) begin
        if (dir == ryc_pkg::DIR_INV) begin
          coef[l][k] = ryc_pkg::INV_C[l][k];
          unique case (ryc_pkg::INV_SEL[l][k])
            ryc_pkg::OP_Y:  opnd[l][k] = {1'b0, luma};
            ryc_pkg::OP_PB: opnd[l][k] = {pb[16], pb};
            default:        opnd[l][k] = {pr[16], pr};
          endcase
        end else begin
          coef[l][k] = ryc_pkg::FWD_C[l][k];
          opnd[l][k] = fop[k];
        end
        term_nxt[l][k] = opnd[l][k] * coef[l][k];
      end
    end
  end

  // Stage B: lane sums. Stage C: magnitude (forward) or clamp (inverse).
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      sum_nxt[l] = ryc_pkg::SW'(term_r[l][0]) + ryc_pkg::SW'(term_r[l][1])
                 + ryc_pkg::SW'(term_r[l][2]);
      absv[l] = sum_r[l][ryc_pkg::SW-1] ? -sum_r[l] : sum_r[l];
      if (dir_r[1] == ryc_pkg::DIR_INV) begin
        neg_c_nxt[l] = 1'b0;
        if (sum_r[l][ryc_pkg::SW-1])
          mag_nxt[l] = '0;
        else if (sum_r[l] > ryc_pkg::INV_TOP)
          mag_nxt[l] = ryc_pkg::INV_TOP[ryc_pkg::AW-1:0];
        else
          mag_nxt[l] = sum_r[l][ryc_pkg::AW-1:0];
      end else begin
        neg_c_nxt[l] = sum_r[l][ryc_pkg::SW-1];
        mag_nxt[l]   = absv[l][ryc_pkg::AW-1:0];
      end
    end
    den_x     = {18'b0, den_b_r};
    dsr_c_nxt = (dir_r[1] == ryc_pkg::DIR_INV) ? ryc_pkg::INV_DSR
                                               : den_x * ryc_pkg::FWD_DIV_K;
  end

  // Stage D: dividend. Forward: mag*2^17 + d/2. Inverse: 2*mag*den + d/2.
  always_comb begin
    half_f = {35'b0, den_c_r} * ryc_pkg::FWD_HALF_K;
    for (int l = 0; l < 3; l++) begin
      prod[l] = {17'b0, mag_r[l]} * {35'b0, den_c_r};
      if (dir_r[2] == ryc_pkg::DIR_INV)
        num_nxt[l] = {prod[l][ryc_pkg::NW-2:0], 1'b0} + ryc_pkg::INV_HALF;
      else
        num_nxt[l] = {mag_r[l], 17'b0} + half_f;
    end
  end

  // Stage E: overflow check, a quotient of 2^18 or more saturates.
  always_comb begin
    dw_nxt.vld = vld_r[3];
    dw_nxt.dir = dir_r[3];
    dw_nxt.dsr = dsr_d_r;
    for (int l = 0; l < 3; l++) begin
      dw_nxt.lane[l].rem = {1'b0, num_r[l]};
      dw_nxt.lane[l].quo = '0;
      dw_nxt.lane[l].neg = neg_d_r[l];
      dw_nxt.lane[l].ovf = {1'b0, num_r[l][ryc_pkg::NW-1:ryc_pkg::QW]} >= dsr_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      dw_r.vld <= 1'b0;
    end else begin
      vld_r    <= {vld_r[2:0], vld};
      dw_r.vld <= dw_nxt.vld;
    end
    dir_r   <= {dir_r[2:0], dir};
    den_a_r <= den;
    den_b_r <= den_a_r;
    den_c_r <= den_b_r;
    term_r  <= term_nxt;
    sum_r   <= sum_nxt;
    mag_r   <= mag_nxt;
    neg_c_r <= neg_c_nxt;
    neg_d_r <= neg_c_r;
    dsr_c_r <= dsr_c_nxt;
    dsr_d_r <= dsr_c_r;
    num_r   <= num_nxt;
    dw_r.dir  <= dw_nxt.dir;
    dw_r.dsr  <= dw_nxt.dsr;
    dw_r.lane <= dw_nxt.lane;
  end

  assign dw = dw_r;

endmodule

// ===== hw/rtl/ryc_div_stage.sv =====
// One restoring division step for three lanes, registered.
// Depends on ryc_pkg; instantiated by ryc_div.
module ryc_div_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  ryc_pkg::div_word_t din,
  output ryc_pkg::div_word_t dout
);

  ryc_pkg::div_word_t nxt, q_r;
  logic [ryc_pkg::NW:0] shd;
  logic [ryc_pkg::NW:0] diff [3];
  logic [2:0] ge;

  always_comb begin
    nxt = din;
    // Divisor aligned to the top quotient bit; the remainder shifts left instead.
    shd = {1'b0, din.dsr, {(ryc_pkg::QW-1){1'b0}}};
    for (int l = 0; l < 3; l++) begin
      ge[l]   = din.lane[l].rem >= shd;
      diff[l] = ge[l] ? din.lane[l].rem - shd : din.lane[l].rem;
      nxt.lane[l].rem = {diff[l][ryc_pkg::NW-1:0], 1'b0};
      nxt.lane[l].quo = {din.lane[l].quo[ryc_pkg::QW-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else begin
      q_r.vld <= nxt.vld;
    end
    q_r.dir  <= nxt.dir;
    q_r.dsr  <= nxt.dsr;
    q_r.lane <= nxt.lane;
  end

  assign dout = q_r;

endmodule

// ===== hw/rtl/ryc_div.sv =====
// Pipelined divider: one quotient bit per stage for three lanes.
// Depends on ryc_pkg and ryc_div_stage.
module ryc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  ryc_pkg::div_word_t din,
  output ryc_pkg::div_word_t dout
);

  ryc_pkg::div_word_t w [ryc_pkg::QW+1];

  assign w[0] = din;

  for (genvar i = 0; i < ryc_pkg::QW; i++) begin : g_stage
    ryc_div_stage u_stage (
      .clk  (clk),
      .rst_n(rst_n),
      .din  (w[i]),
      .dout (w[i+1])
    );
  end

  assign dout = w[ryc_pkg::QW];

endmodule

// ===== hw/rtl/rgb_ypbpr_color_converter.sv =====
// Top level of the BT.601 RGB / YPbPr converter: input and output registers,
// configuration registers, front pipeline and divider. Depends on ryc_pkg,
// ryc_prep and ryc_div.
//
//   channel  ports                              handshake
//   input    in_* fields                        start high, busy low
//   result   out_* fields                       out_valid, one cycle
//   config   cfg_we, cfg_index, cfg_data        cfg_we high
//
// An item enters every cycle; after it is accepted it passes through
// one input stage, five front stages, eighteen divider stages
// (one quotient bit each) and one output stage. busy is always low.
// Synchronous reset empties the pipeline and sets the direction to forward
// and the maximum value to 255. Results cannot be held off, so nothing stalls.
module rgb_ypbpr_color_converter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        in_red_in,
  input  logic [15:0]        in_green_in,
  input  logic [15:0]        in_blue_in,
  input  logic [16:0]        in_luma_in,
  input  logic signed [16:0] in_blue_diff_in,
  input  logic signed [16:0] in_red_diff_in,
  output logic               out_valid,
  output logic [16:0]        out_luma_out,
  output logic signed [16:0] out_blue_diff_out,
  output logic signed [16:0] out_red_diff_out,
  output logic [15:0]        out_red_out,
  output logic [15:0]        out_green_out,
  output logic [15:0]        out_blue_out,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);

  logic        direction_r;
  logic [15:0] max_value_r;
  logic        s1_vld_r, s1_dir_r;
  logic [15:0] s1_den_r, s1_red_r, s1_green_r, s1_blue_r;
  logic [16:0] s1_luma_r;
  logic signed [16:0] s1_pb_r, s1_pr_r;
  ryc_pkg::div_word_t pre_w, div_w;

  logic [ryc_pkg::QW-1:0] q [3];
  logic [16:0] dmag [3];
  logic        out_valid_r;
  logic [16:0] luma_r, luma_nxt;
  logic signed [16:0] pb_r, pb_nxt, pr_r, pr_nxt;
  logic [15:0] red_r, red_nxt, green_r, green_nxt, blue_r, blue_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= ryc_pkg::DIR_FWD;
      max_value_r <= 16'd255;
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ryc_pkg::CFG_DIRECTION: direction_r <= cfg_data[0];
          ryc_pkg::CFG_MAX_VALUE: max_value_r <= cfg_data;
        endcase
      end
      s1_vld_r    <= start && !busy;
      out_valid_r <= div_w.vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_dir_r   <= direction_r;
    // A zero maximum counts as one in the forward direction.
    s1_den_r   <= (direction_r == ryc_pkg::DIR_FWD && max_value_r == 16'd0)
                  ? 16'd1 : max_value_r;
    s1_red_r   <= in_red_in;
    s1_green_r <= in_green_in;
    s1_blue_r  <= in_blue_in;
    s1_luma_r  <= in_luma_in;
    s1_pb_r    <= in_blue_diff_in;
    s1_pr_r    <= in_red_diff_in;
  end

  ryc_prep u_prep (
    .clk  (clk),
    .rst_n(rst_n),
    .vld  (s1_vld_r),
    .dir  (s1_dir_r),
    .den  (s1_den_r),
    .red  (s1_red_r),
    .green(s1_green_r),
    .blue (s1_blue_r),
    .luma (s1_luma_r),
    .pb   (s1_pb_r),
    .pr   (s1_pr_r),
    .dw   (pre_w)
  );

  ryc_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .din  (pre_w),
    .dout (div_w)
  );

  // Output clamps and sign restore.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      q[l] = div_w.lane[l].quo;
      dmag[l] = (div_w.lane[l].ovf || q[l] > 18'd32768) ? 17'd32768 : q[l][16:0];
    end
    luma_nxt  = '0;
    pb_nxt    = '0;
    pr_nxt    = '0;
    red_nxt   = '0;
    green_nxt = '0;
    blue_nxt  = '0;
    if (div_w.dir == ryc_pkg::DIR_INV) begin
      red_nxt   = q[0][15:0];
      green_nxt = q[1][15:0];
      blue_nxt  = q[2][15:0];
    end else begin
      if (div_w.lane[0].neg)
        luma_nxt = '0;
      else if (div_w.lane[0].ovf || q[0] > 18'd65536)
        luma_nxt = 17'd65536;
      else
        luma_nxt = q[0][16:0];
      pb_nxt = div_w.lane[1].neg ? -$signed(dmag[1]) : $signed(dmag[1]);
      pr_nxt = div_w.lane[2].neg ? -$signed(dmag[2]) : $signed(dmag[2]);
    end
  end

  always_ff @(posedge clk) begin
    luma_r  <= luma_nxt;
    pb_r    <= pb_nxt;
    pr_r    <= pr_nxt;
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_luma_out      = luma_r;
  assign out_blue_diff_out = pb_r;
  assign out_red_diff_out  = pr_r;
  assign out_red_out       = red_r;
  assign out_green_out     = green_r;
  assign out_blue_out      = blue_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##25 out_valid)
    else $error("accepted item did not reach the output after 25 cycles");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 25))
    else $error("result without a matching accepted item");

  a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_luma_out <= 17'd65536)
    else $error("luma out of range");

  a_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_red_out != 16'd0 || out_green_out != 16'd0 ||
                  out_blue_out != 16'd0)
    |-> out_luma_out == 17'd0 && out_blue_diff_out == 17'sd0 &&
        out_red_diff_out == 17'sd0)
    else $error("both directions carry values in one item");

endmodule
